// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the I2C master engine RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
		else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the I2C master byte engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

	localparam int unsigned HALF_W      = 16;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned BIT_IDX_W   = 4;
	localparam int unsigned APB_ADDR_W  = 3;
	localparam int unsigned APB_DATA_W  = 32;

	localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd100;

	// Register index taken from paddr[2]
	localparam logic REG_HALF_PERIOD = 1'b0;

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_START,
		OP_STOP,
		OP_WRITE,
		OP_READ
	} op_t;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_STOP  = 2'd1,
		ACT_WRITE = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		PH_NONE,
		PH_FIRST,
		PH_SECOND
	} phase_t;

	typedef struct packed {
		logic              cmd_valid;
		logic [1:0]        action;
		logic [BYTE_W-1:0] tx_byte;
		logic              send_nack;
		logic              sda_in;
	} item_t;

	typedef struct packed {
		logic              scl_low;
		logic              sda_low;
		logic              busy;
		logic              done;
		logic [BYTE_W-1:0] rx_byte;
		logic              nacked;
	} result_t;

endpackage

`default_nettype wire

// File: hdl/i2cm_regs.sv
// ----------------------------------------------------------------------------
// i2cm_regs
// APB register block holding the half-period tick count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cm_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [i2cm_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [i2cm_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [i2cm_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                  pready,
	output logic      [i2cm_pkg::HALF_W-1:0]      half_period
);
	import i2cm_pkg::*;

	logic [HALF_W-1:0] half_q;
	logic              wr_en;
	logic              sel_half;

	assign sel_half = (paddr[APB_ADDR_W-1] == REG_HALF_PERIOD);
	assign wr_en    = psel && penable && pwrite && sel_half;
	assign pready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_PERIOD_RESET;
		end else if (wr_en) begin
			half_q <= pwdata[HALF_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_half) begin
			prdata = {{(APB_DATA_W-HALF_W){1'b0}}, half_q};
		end
	end

	assign half_period = half_q;

endmodule

`default_nettype wire

// File: hdl/i2cm_core.sv
// ----------------------------------------------------------------------------
// i2cm_core
// Bus sequencer: applies one tick to the engine state and forms its result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module i2cm_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step_en,
	input  wire i2cm_pkg::item_t             item,
	input  wire logic [i2cm_pkg::HALF_W-1:0] half_period,
	output i2cm_pkg::result_t                result
);
	import i2cm_pkg::*;

	op_t                  op_q, op_d;
	phase_t               phase_q, phase_d;
	logic [HALF_W-1:0]    tick_q, tick_d;
	logic [BIT_IDX_W-1:0] bit_q, bit_d;
	logic [BYTE_W-1:0]    shift_q, shift_d;
	logic                 scl_q, scl_d;
	logic                 sda_q, sda_d;
	logic                 ack_q, ack_d;
	logic [BYTE_W-1:0]    rx_q, rx_d;
	logic                 nack_q, nack_d;

	logic [HALF_W-1:0]    half_eff;
	logic [HALF_W:0]      cnt_inc;
	logic                 phase_end;
	logic                 done;

	// A zero half period behaves as one tick
	assign half_eff  = (half_period == '0) ? {{(HALF_W-1){1'b0}}, 1'b1} : half_period;
	assign cnt_inc   = {1'b0, tick_q} + {{HALF_W{1'b0}}, 1'b1};
	assign phase_end = (cnt_inc >= {1'b0, half_eff});

	assign done = (op_q != OP_IDLE) && phase_end && (phase_q == PH_SECOND)
		&& ((op_q == OP_START) || (op_q == OP_STOP) || bit_q[BIT_IDX_W-1]);

	// Next state
	always_comb begin
		op_d = op_q;
		if (op_q == OP_IDLE) begin
			if (item.cmd_valid) begin
				case (action_t'(item.action))
					ACT_START: op_d = OP_START;
					ACT_STOP:  op_d = OP_STOP;
					ACT_WRITE: op_d = OP_WRITE;
					ACT_READ:  op_d = OP_READ;
					default:   op_d = OP_IDLE;
				endcase
			end
		end else if (done) begin
			op_d = OP_IDLE;
		end
	end

	// Datapath and line updates
	always_comb begin
		tick_d  = tick_q;
		phase_d = phase_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		ack_d   = ack_q;
		rx_d    = rx_q;
		nack_d  = nack_q;
		if (op_q == OP_IDLE) begin
			if (item.cmd_valid) begin
				tick_d  = '0;
				phase_d = PH_FIRST;
				bit_d   = '0;
				case (action_t'(item.action))
					ACT_START: sda_d = 1'b0;
					ACT_STOP:  sda_d = 1'b1;
					ACT_WRITE: begin
						sda_d   = ~item.tx_byte[BYTE_W-1];
						shift_d = {item.tx_byte[BYTE_W-2:0], 1'b0};
					end
					ACT_READ: begin
						shift_d = '0;
						nack_d  = item.send_nack;
						sda_d   = 1'b0;
					end
					default: ;
				endcase
			end
		end else if (!phase_end) begin
			tick_d = cnt_inc[HALF_W-1:0];
		end else begin
			tick_d = '0;
			case (op_q)
				OP_START: begin
					if (phase_q == PH_FIRST) begin
						sda_d   = 1'b1;
						phase_d = PH_SECOND;
					end else begin
						scl_d = 1'b1;
					end
				end
				OP_STOP: begin
					if (phase_q == PH_FIRST) begin
						scl_d   = 1'b0;
						phase_d = PH_SECOND;
					end else begin
						sda_d = 1'b0;
					end
				end
				OP_WRITE, OP_READ: begin
					if (phase_q == PH_FIRST) begin
						// release SCL and sample the bit
						scl_d = 1'b0;
						if (op_q == OP_READ && !bit_q[BIT_IDX_W-1]) begin
							shift_d = {shift_q[BYTE_W-2:0], item.sda_in};
						end else if (op_q == OP_WRITE && bit_q[BIT_IDX_W-1]) begin
							ack_d = item.sda_in;
						end
						phase_d = PH_SECOND;
					end else begin
						scl_d = 1'b1;
						if (bit_q[BIT_IDX_W-1]) begin
							if (op_q == OP_READ) begin
								rx_d = shift_q;
							end
						end else begin
							// advance to the next bit and set SDA for it
							bit_d = bit_q + {{(BIT_IDX_W-1){1'b0}}, 1'b1};
							if (op_q == OP_WRITE && !bit_d[BIT_IDX_W-1]) begin
								sda_d   = ~shift_q[BYTE_W-1];
								shift_d = {shift_q[BYTE_W-2:0], 1'b0};
							end else if (op_q == OP_READ && bit_d[BIT_IDX_W-1]) begin
								sda_d = ~nack_q;
							end else begin
								sda_d = 1'b0;
							end
							phase_d = PH_FIRST;
						end
					end
				end
				default: ;
			endcase
			if (done) begin
				phase_d = PH_NONE;
				bit_d   = '0;
			end
		end
	end

	// Result for this tick
	always_comb begin
		result.scl_low = scl_d;
		result.sda_low = sda_d;
		result.busy    = (op_d != OP_IDLE);
		result.done    = done;
		result.rx_byte = rx_d;
		result.nacked  = ack_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_IDLE;
			phase_q <= PH_NONE;
			tick_q  <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			scl_q   <= 1'b0;
			sda_q   <= 1'b0;
			ack_q   <= 1'b0;
			rx_q    <= '0;
			nack_q  <= 1'b0;
		end else if (step_en) begin
			op_q    <= op_d;
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			ack_q   <= ack_d;
			rx_q    <= rx_d;
			nack_q  <= nack_d;
		end
	end

	`ASSERT_IMPL(a_done_needs_op, clk, arst_n, step_en && done, op_q != OP_IDLE, "done without command")
	`ASSERT_ALWAYS(a_bit_range, clk, arst_n, bit_q <= 4'd8, "bit index beyond ninth bit")
	`ASSERT_IMPL(a_idle_clean, clk, arst_n, op_q == OP_IDLE, (phase_q == PH_NONE) && (bit_q == '0), "idle with live sequence")
	`ASSERT_NEXT(a_idle_lines_hold, clk, arst_n, step_en && (op_q == OP_IDLE) && !item.cmd_valid, (scl_q == $past(scl_q)) && (sda_q == $past(sda_q)), "lines moved while idle")

endmodule

`default_nettype wire

// File: hdl/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Open-drain I2C master: start, stop, write byte and read byte sequencing.
// ----------------------------------------------------------------------------
// Each transaction on the item channel is one tick of bus timing and yields
// exactly one result transaction. A tick is held in an input register, the
// sequencer applies it to the engine state, and the result is held in an
// output register, so a new tick is taken every clock cycle while the
// result side keeps up; the result is presented from the output register
// once the tick has passed through the input register and the sequencer.
// Line changes are spaced by half_period ticks (register 0, reset 100, zero
// acts as one). Commands offered while a command is in progress are
// dropped. scl_drive_low and sda_drive_low drive the open-drain pull-downs.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_engine (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// APB configuration
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [i2cm_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [i2cm_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [i2cm_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                  pready,
	// tick channel
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  wire logic                             cmd_valid,
	input  wire logic [1:0]                       action,
	input  wire logic [i2cm_pkg::BYTE_W-1:0]      tx_byte,
	input  wire logic                             send_nack,
	input  wire logic                             sda_in,
	// result channel
	output logic                                  res_valid,
	input  wire logic                             res_stall,
	output logic                                  scl_drive_low,
	output logic                                  sda_drive_low,
	output logic                                  busy_res,
	output logic                                  done_res,
	output logic      [i2cm_pkg::BYTE_W-1:0]      rx_byte,
	output logic                                  slave_nacked
);
	import i2cm_pkg::*;

	logic [HALF_W-1:0] half_period;
	logic              valid_s1;
	item_t             item_s1;
	logic              res_valid_q;
	result_t           res_q;
	result_t           step_res;
	logic              advance;
	logic              step_en;

	i2cm_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.half_period (half_period)
	);

	// Move the tick on when the result register is free or being emptied
	assign advance    = !res_valid_q || !res_stall;
	assign step_en    = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= '{cmd_valid: cmd_valid, action: action, tx_byte: tx_byte,
				send_nack: send_nack, sda_in: sda_in};
		end
	end

	i2cm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (step_en),
		.item        (item_s1),
		.half_period (half_period),
		.result      (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_q <= step_res;
		end
	end

	assign res_valid     = res_valid_q;
	assign scl_drive_low = res_q.scl_low;
	assign sda_drive_low = res_q.sda_low;
	assign busy_res      = res_q.busy;
	assign done_res      = res_q.done;
	assign rx_byte       = res_q.rx_byte;
	assign slave_nacked  = res_q.nacked;

endmodule

`default_nettype wire
